// ----- src/button_macro_player_defines.svh -----
// Assertion helpers used by the macro player top level.
`ifndef BUTTON_MACRO_PLAYER_DEFINES_SVH
`define BUTTON_MACRO_PLAYER_DEFINES_SVH

// Check that prop holds at every clock edge outside reset.
`define BMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that post holds in the cycle after pre.
`define BMP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- src/bmp_pkg.sv -----
`default_nettype none

package bmp_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned TickW    = 16;
  localparam int unsigned PosW     = 8;
  localparam int unsigned LenW     = 9;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned SlotSelW = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 36;
  localparam int unsigned PlayW    = 4;
  // slots that have mode, trigger and length registers
  localparam int unsigned HwSlots  = 4;

  localparam logic [WordW-1:0] NO_ANALOG = '1;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef enum logic [ModeW-1:0] {
    MODE_OFF               = 3'd0,
    MODE_HOLD              = 3'd1,
    MODE_COMBO_HOLD        = 3'd2,
    MODE_TOGGLE_ONCE       = 3'd3,
    MODE_COMBO_TOGGLE_ONCE = 3'd4,
    MODE_TOGGLE_LOOP       = 3'd5,
    MODE_COMBO_TOGGLE_LOOP = 3'd6
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SLOT_MODES   = 3'd0,
    REG_COMBO_MASK   = 3'd1,
    REG_TRIG0        = 3'd2,
    REG_TRIG1        = 3'd3,
    REG_TRIG2        = 3'd4,
    REG_TRIG3        = 3'd5,
    REG_SLOT_LENGTHS = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] hold;
    logic [WordW-1:0] buttons;
    logic [WordW-1:0] analog;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    mode_e            mode;
    logic [WordW-1:0] start_mask;
    logic [WordW-1:0] combo_mask;
    logic [LenW-1:0]  len;
  } slot_cfg_t;

  typedef struct packed {
    logic             tick_accept;
    logic             active;
    logic             s1_valid;
    logic             s1_active;
    logic             commit;
    logic [WordW-1:0] held;
    logic [WordW-1:0] edges;
    logic             load_we;
    logic [PosW-1:0]  load_index;
    entry_t           load_entry;
  } slot_req_t;

  typedef struct packed {
    logic             playing;
    logic [WordW-1:0] cancel;
    logic [WordW-1:0] buttons;
    logic             analog_valid;
    logic [WordW-1:0] analog;
  } slot_res_t;

endpackage

`default_nettype wire

// ----- src/bmp_in_if.sv -----
`default_nettype none

interface bmp_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] held_buttons;
  logic [31:0] pressed_edges;
  logic [1:0]  load_slot;
  logic [7:0]  load_index;
  logic [15:0] load_time;
  logic [31:0] load_buttons;
  logic [31:0] load_analog;

  modport source (
    output valid, operation, held_buttons, pressed_edges, load_slot, load_index,
           load_time, load_buttons, load_analog,
    input  ready
  );

  modport sink (
    input  valid, operation, held_buttons, pressed_edges, load_slot, load_index,
           load_time, load_buttons, load_analog,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/bmp_out_if.sv -----
`default_nettype none

interface bmp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cancel_mask;
  logic [31:0] macro_buttons;
  logic        analog_valid;
  logic [31:0] macro_analog;
  logic [3:0]  playing_slots;

  modport source (
    output valid, cancel_mask, macro_buttons, analog_valid, macro_analog, playing_slots,
    input  ready
  );

  modport sink (
    input  valid, cancel_mask, macro_buttons, analog_valid, macro_analog, playing_slots,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/button_macro_player.sv -----
// Channel   Dir  Beat payload
// in_i      in   operation, held/pressed buttons, load slot/index/time/buttons/analog
// out_o     out  cancel mask, macro buttons, analog valid/word, playing slots
// cfg_*     in   register index and data, one write per cycle, no handshake
//
// Each tick enters the in-flight stage, which reads the entry RAM (one bank per
// slot), then the output register on out_o; one item per cycle is sustained
// while out_o is not stalled. Slot state is forwarded from the in-flight tick.
// Load beats produce no result and write the bank in the accept cycle.
// A stalled output holds the in-flight tick and drops in_i.ready.
// Reset clears the slot play state and configuration; entry RAMs are not cleared.
`default_nettype none

module button_macro_player #(
  parameter int unsigned SLOT_COUNT       = 4,
  parameter int unsigned ENTRIES_PER_SLOT = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  bmp_in_if.sink                              in_i,
  bmp_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [bmp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [bmp_pkg::CfgDataW-1:0]   cfg_data_i
);

  `include "button_macro_player_defines.svh"

  // length cap, kept within the 9-bit length field
  localparam int unsigned LenCap = (ENTRIES_PER_SLOT < 511) ? ENTRIES_PER_SLOT : 511;

  // configuration registers
  logic [bmp_pkg::HwSlots*bmp_pkg::ModeW-1:0] slot_modes_q;
  logic [bmp_pkg::WordW-1:0]                  combo_mask_q;
  logic [bmp_pkg::WordW-1:0]                  trig_q [bmp_pkg::HwSlots];
  logic [bmp_pkg::HwSlots*bmp_pkg::LenW-1:0]  slot_lengths_q;

  // tick in flight between accept and result
  logic s1_valid_q;
  logic s1_active_q;

  // output register
  logic                         out_valid_q;
  logic [bmp_pkg::WordW-1:0]    out_cancel_q;
  logic [bmp_pkg::WordW-1:0]    out_buttons_q;
  logic                         out_analog_valid_q;
  logic [bmp_pkg::WordW-1:0]    out_analog_q;
  logic [bmp_pkg::PlayW-1:0]    out_playing_q;

  logic in_ready;
  logic in_accept;
  logic tick_accept;
  logic load_accept;
  logic index_ok;
  logic active;
  logic s1_adv;
  logic commit;

  bmp_pkg::slot_cfg_t slot_cfg [SLOT_COUNT];
  bmp_pkg::slot_req_t slot_req [SLOT_COUNT];
  bmp_pkg::slot_res_t slot_res [SLOT_COUNT];
  bmp_pkg::entry_t    load_entry;

  logic [bmp_pkg::WordW-1:0] cancel_d;
  logic [bmp_pkg::WordW-1:0] buttons_d;
  logic                      analog_valid_d;
  logic [bmp_pkg::WordW-1:0] analog_d;
  logic [bmp_pkg::PlayW-1:0] playing_d;

  // Handshake: the in-flight tick moves to the output register when that
  // register is empty or being drained this cycle.
  assign s1_adv      = !out_valid_q || out_o.ready;
  assign commit      = s1_valid_q && s1_adv;
  assign in_ready    = !s1_valid_q || s1_adv;
  assign in_i.ready  = in_ready;
  assign in_accept   = in_i.valid && in_ready;
  assign tick_accept = in_accept && (bmp_pkg::op_e'(in_i.operation) == bmp_pkg::OP_TICK);
  assign load_accept = in_accept && (bmp_pkg::op_e'(in_i.operation) == bmp_pkg::OP_LOAD);
  assign index_ok    = 32'(in_i.load_index) < ENTRIES_PER_SLOT;
  // with every slot off, a tick leaves the state alone
  assign active      = slot_modes_q != '0;

  assign load_entry.hold    = in_i.load_time;
  assign load_entry.buttons = in_i.load_buttons;
  assign load_entry.analog  = in_i.load_analog;

  // Configuration writes; indexes past the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_modes_q   <= '0;
      combo_mask_q   <= '0;
      trig_q         <= '{default: '0};
      slot_lengths_q <= '0;
    end else if (cfg_we_i) begin
      unique case (bmp_pkg::reg_idx_e'(cfg_idx_i))
        bmp_pkg::REG_SLOT_MODES:   slot_modes_q   <= cfg_data_i[11:0];
        bmp_pkg::REG_COMBO_MASK:   combo_mask_q   <= cfg_data_i[31:0];
        bmp_pkg::REG_TRIG0:        trig_q[0]      <= cfg_data_i[31:0];
        bmp_pkg::REG_TRIG1:        trig_q[1]      <= cfg_data_i[31:0];
        bmp_pkg::REG_TRIG2:        trig_q[2]      <= cfg_data_i[31:0];
        bmp_pkg::REG_TRIG3:        trig_q[3]      <= cfg_data_i[31:0];
        bmp_pkg::REG_SLOT_LENGTHS: slot_lengths_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Per-slot configuration view, request bundle and slot engine.
  for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_slot
    logic [bmp_pkg::LenW-1:0] len_raw;

    if (s < bmp_pkg::HwSlots) begin : g_cfg
      assign len_raw                = slot_lengths_q[s*bmp_pkg::LenW +: bmp_pkg::LenW];
      assign slot_cfg[s].mode       =
        bmp_pkg::mode_e'(slot_modes_q[s*bmp_pkg::ModeW +: bmp_pkg::ModeW]);
      assign slot_cfg[s].start_mask = trig_q[s];
    end else begin : g_nocfg
      // slots past the register set: off, no trigger, no macro
      assign len_raw                = '0;
      assign slot_cfg[s].mode       = bmp_pkg::MODE_OFF;
      assign slot_cfg[s].start_mask = '0;
    end

    assign slot_cfg[s].combo_mask = combo_mask_q;
    // clamp the length to the bank depth
    assign slot_cfg[s].len = (len_raw > bmp_pkg::LenW'(LenCap)) ?
                             bmp_pkg::LenW'(LenCap) : len_raw;

    assign slot_req[s].tick_accept = tick_accept;
    assign slot_req[s].active      = active;
    assign slot_req[s].s1_valid    = s1_valid_q;
    assign slot_req[s].s1_active   = s1_active_q;
    assign slot_req[s].commit      = commit;
    assign slot_req[s].held        = in_i.held_buttons;
    assign slot_req[s].edges       = in_i.pressed_edges;
    assign slot_req[s].load_we     = load_accept && index_ok && (32'(in_i.load_slot) == s);
    assign slot_req[s].load_index  = in_i.load_index;
    assign slot_req[s].load_entry  = load_entry;

    bmp_slot #(
      .ENTRIES_PER_SLOT (ENTRIES_PER_SLOT)
    ) u_slot (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (slot_cfg[s]),
      .req_i  (slot_req[s]),
      .res_o  (slot_res[s])
    );
  end

  // Only the first four slots are reported.
  for (genvar p = 0; p < bmp_pkg::PlayW; p++) begin : g_play
    if (p < SLOT_COUNT) begin : g_on
      assign playing_d[p] = slot_res[p].playing;
    end else begin : g_off
      assign playing_d[p] = 1'b0;
    end
  end

  // Merge slot results: OR the buttons and cancels, take the analog word
  // of the highest numbered slot that has one.
  always_comb begin
    cancel_d       = '0;
    buttons_d      = '0;
    analog_valid_d = 1'b0;
    analog_d       = bmp_pkg::NO_ANALOG;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      cancel_d  = cancel_d  | slot_res[s].cancel;
      buttons_d = buttons_d | slot_res[s].buttons;
      if (slot_res[s].analog_valid) begin
        analog_valid_d = 1'b1;
        analog_d       = slot_res[s].analog;
      end
    end
  end

  // Advance the in-flight stage: a new tick loads it, a commit empties it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_active_q <= 1'b0;
    end else if (tick_accept) begin
      s1_valid_q  <= 1'b1;
      s1_active_q <= active;
    end else if (commit) begin
      s1_valid_q  <= 1'b0;
    end
  end

  // Output register: hold the beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_cancel_q       <= cancel_d;
      out_buttons_q      <= buttons_d;
      out_analog_valid_q <= analog_valid_d;
      out_analog_q       <= analog_d;
      out_playing_q      <= playing_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cancel_mask   = out_cancel_q;
  assign out_o.macro_buttons = out_buttons_q;
  assign out_o.analog_valid  = out_analog_valid_q;
  assign out_o.macro_analog  = out_analog_q;
  assign out_o.playing_slots = out_playing_q;

  `BMP_ASSERT_NEXT(a_tick_in_flight, tick_accept, s1_valid_q,
                   "accepted tick did not enter the read stage")
  `BMP_ASSERT_NEXT(a_commit_fills_out, commit, out_valid_q,
                   "committed tick did not reach the output register")
  `BMP_ASSERT_NEXT(a_stall_keeps_tick, s1_valid_q && !commit, s1_valid_q,
                   "stalled tick was lost")
  `BMP_ASSERT(a_analog_none, !out_valid_q || out_analog_valid_q ||
                             (out_analog_q == bmp_pkg::NO_ANALOG),
              "analog word without valid flag")

endmodule

`default_nettype wire

// ----- src/bmp_ram.sv -----
`default_nettype none

module bmp_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/bmp_slot.sv -----
`default_nettype none

module bmp_slot #(
  parameter int unsigned ENTRIES_PER_SLOT = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bmp_pkg::slot_cfg_t cfg_i,
  input  wire bmp_pkg::slot_req_t req_i,
  output bmp_pkg::slot_res_t      res_o
);

  localparam int unsigned AddrW = $clog2(ENTRIES_PER_SLOT);

  // committed slot state
  logic                       playing_q;
  logic [bmp_pkg::TickW-1:0]  tick_q;
  logic [bmp_pkg::PosW-1:0]   pos_q;

  // state after the trigger step, waiting for the entry read
  logic                       t_playing_q;
  logic [bmp_pkg::TickW-1:0]  t_tick_q;
  logic [bmp_pkg::PosW-1:0]   t_pos_q;
  logic [bmp_pkg::WordW-1:0]  cancel_q;

  logic                       cur_playing;
  logic [bmp_pkg::TickW-1:0]  cur_tick;
  logic [bmp_pkg::PosW-1:0]   cur_pos;

  logic                       tr_playing;
  logic [bmp_pkg::TickW-1:0]  tr_tick;
  logic [bmp_pkg::PosW-1:0]   tr_pos;
  logic [bmp_pkg::WordW-1:0]  tr_cancel;

  logic                       nx_playing;
  logic [bmp_pkg::TickW-1:0]  nx_tick;
  logic [bmp_pkg::PosW-1:0]   nx_pos;

  logic [bmp_pkg::WordW-1:0]  comb_hit;
  logic [bmp_pkg::WordW-1:0]  hold_hit;
  logic [bmp_pkg::WordW-1:0]  edge_hit;
  logic                       is_combo;
  logic                       is_once;
  logic                       run;
  logic [bmp_pkg::TickW-1:0]  tick_inc;
  logic [bmp_pkg::LenW-1:0]   pos_inc;

  logic [bmp_pkg::EntryW-1:0] rd_data;
  bmp_pkg::entry_t            entry;

  assign entry = bmp_pkg::entry_t'(rd_data);

  assign is_combo = (cfg_i.mode == bmp_pkg::MODE_COMBO_HOLD) ||
                    (cfg_i.mode == bmp_pkg::MODE_COMBO_TOGGLE_ONCE) ||
                    (cfg_i.mode == bmp_pkg::MODE_COMBO_TOGGLE_LOOP);
  assign is_once  = (cfg_i.mode == bmp_pkg::MODE_TOGGLE_ONCE) ||
                    (cfg_i.mode == bmp_pkg::MODE_COMBO_TOGGLE_ONCE);

  // advance step on the entry read for the tick in flight
  assign run      = req_i.s1_active && t_playing_q && (cfg_i.len != '0);
  assign tick_inc = t_tick_q + 1'b1;
  assign pos_inc  = {1'b0, t_pos_q} + 1'b1;

  always_comb begin
    nx_playing = t_playing_q;
    nx_tick    = t_tick_q;
    nx_pos     = t_pos_q;
    if (run) begin
      if (tick_inc >= entry.hold) begin
        nx_tick = '0;
        if (pos_inc >= cfg_i.len) begin
          nx_pos = '0;
          if (is_once) begin
            nx_playing = 1'b0;
          end
        end else begin
          nx_pos = pos_inc[bmp_pkg::PosW-1:0];
        end
      end else begin
        nx_tick = tick_inc;
      end
    end
  end

  // forward the in-flight result to the next tick
  assign cur_playing = req_i.s1_valid ? nx_playing : playing_q;
  assign cur_tick    = req_i.s1_valid ? nx_tick    : tick_q;
  assign cur_pos     = req_i.s1_valid ? nx_pos     : pos_q;

  assign comb_hit = req_i.held  & cfg_i.combo_mask;
  assign hold_hit = req_i.held  & cfg_i.start_mask;
  assign edge_hit = req_i.edges & cfg_i.start_mask;

  // trigger step: start, stop or toggle by mode
  always_comb begin
    tr_playing = cur_playing;
    tr_tick    = cur_tick;
    tr_pos     = cur_pos;
    tr_cancel  = '0;
    if (req_i.active) begin
      unique case (cfg_i.mode) inside
        bmp_pkg::MODE_HOLD, bmp_pkg::MODE_COMBO_HOLD: begin
          if (is_combo && (comb_hit == '0)) begin
            tr_playing = 1'b0;
          end else begin
            if (is_combo) begin
              tr_cancel = comb_hit;
            end
            if (hold_hit != '0) begin
              if (!cur_playing) begin
                tr_playing = 1'b1;
                tr_tick    = '0;
                tr_pos     = '0;
              end
              tr_cancel = tr_cancel | hold_hit;
            end else begin
              tr_playing = 1'b0;
            end
          end
        end
        bmp_pkg::MODE_TOGGLE_ONCE, bmp_pkg::MODE_COMBO_TOGGLE_ONCE,
        bmp_pkg::MODE_TOGGLE_LOOP, bmp_pkg::MODE_COMBO_TOGGLE_LOOP: begin
          if (!(is_combo && (comb_hit == '0))) begin
            if (is_combo) begin
              tr_cancel = comb_hit;
            end
            if (edge_hit != '0) begin
              if (!cur_playing) begin
                tr_playing = 1'b1;
                tr_tick    = '0;
                tr_pos     = '0;
              end else begin
                tr_playing = 1'b0;
              end
              tr_cancel = tr_cancel | edge_hit;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      tick_q    <= '0;
      pos_q     <= '0;
    end else if (req_i.commit) begin
      playing_q <= nx_playing;
      tick_q    <= nx_tick;
      pos_q     <= nx_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_playing_q <= 1'b0;
      t_tick_q    <= '0;
      t_pos_q     <= '0;
    end else if (req_i.tick_accept) begin
      t_playing_q <= tr_playing;
      t_tick_q    <= tr_tick;
      t_pos_q     <= tr_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.tick_accept) begin
      cancel_q <= tr_cancel;
    end
  end

  bmp_ram #(
    .WIDTH (bmp_pkg::EntryW),
    .DEPTH (ENTRIES_PER_SLOT)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.load_we),
    .waddr_i (AddrW'(req_i.load_index)),
    .wdata_i (req_i.load_entry),
    .re_i    (req_i.tick_accept),
    .raddr_i (AddrW'(tr_pos)),
    .rdata_o (rd_data)
  );

  assign res_o.playing      = nx_playing;
  assign res_o.cancel       = cancel_q;
  assign res_o.buttons      = run ? entry.buttons : '0;
  assign res_o.analog_valid = run && (entry.analog != bmp_pkg::NO_ANALOG);
  assign res_o.analog       = entry.analog;

endmodule

`default_nettype wire
